// ----- rtl/core/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, widths and constants of the supply setpoint and measurement
// block.
// ----------------------------------------------------------------------------
package ssm_pkg;

	// payload widths
	localparam int ACT_W   = 2;
	localparam int SP_W    = 16;
	localparam int ADC_W   = 12;
	localparam int CMP_W   = 14;
	localparam int VOLT_W  = 12;
	localparam int CURR_W  = 16;
	localparam int CNT_W   = 7;
	localparam int SUM_W   = 19;
	localparam int AMPS_W  = 7;

	// APB port
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 1;
	localparam int REG_LSB   = 2;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
	localparam logic [CNT_W-1:0]     SAMPLE_COUNT_RST = 7'd7;

	// scaling constants
	localparam logic [11:0] ADC_FULL_SCALE = 12'd4095;
	localparam logic [11:0] CENTI_SCALE    = 12'd3300;
	localparam logic [21:0] CURRENT_SCALE  = 22'd3300000;
	localparam logic [15:0] AMP_RATIO      = 16'd33000;
	localparam logic [CMP_W-1:0] VCMP_RST  = 14'd15;

	// setpoint scaling by reciprocal multiplication
	// sp*5/33: ceil(5 * 2^21 / 33), exact for any 16-bit setpoint
	localparam int          CMP_RECIP_W = 19;
	localparam logic [18:0] CMP_RECIP   = 19'd317751;
	localparam int          CMP_SHIFT   = 21;
	localparam int          CMP_PROD_W  = SP_W + CMP_RECIP_W;
	// sp/1000: ceil(2^26 / 1000), exact for any 16-bit setpoint
	localparam int          AMPS_RECIP_W = 17;
	localparam logic [16:0] AMPS_RECIP   = 17'd67109;
	localparam int          AMPS_SHIFT   = 26;
	localparam int          AMPS_PROD_W  = SP_W + AMPS_RECIP_W;

	// divider geometry
	localparam int DIV_W     = 41;                  // widest numerator
	localparam int DEN_W     = 20;                  // N*4095 < 2^19, one spare
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int VNUM_W    = SUM_W + 12;
	localparam int LHS_W     = SUM_W + 16;
	localparam int LIM_W     = AMPS_W + SUM_W;

	typedef enum logic [ACT_W-1:0] {
		ACT_RELAY  = 2'd0,
		ACT_VSET   = 2'd1,
		ACT_CSET   = 2'd2,
		ACT_SAMPLE = 2'd3
	} action_t;

	typedef enum logic {
		DIV_VOLT,
		DIV_CURR
	} div_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CHECK,
		ST_WAIT_VOLT,
		ST_WAIT_CURR,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic     take;
		logic     relay_set;
		logic     accumulate;
		logic     prep;
		logic     div_start;
		div_sel_t div_sel;
		logic     store_vcmp;
		logic     store_ccmp;
		logic     store_amps;
		logic     store_volt;
		logic     store_curr;
		logic     close_window;
		logic     load_out;
	} ssm_cmd_t;

	typedef struct packed {
		action_t action;
		logic    vsp_changed;
		logic    csp_changed;
		logic    window_full;
		logic    plausible;
		logic    div_done;
		logic    out_free;
	} ssm_status_t;

endpackage

// ----- rtl/core/ssm_item_if.sv -----
// ----------------------------------------------------------------------------
// ssm_item_if
// Request channel: one command or ADC sample pair per handshake.
// ----------------------------------------------------------------------------
interface ssm_item_if import ssm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic              power_on;
	logic [SP_W-1:0]   setpoint;
	logic [ADC_W-1:0]  adc_high_side;
	logic [ADC_W-1:0]  adc_low_side;

	modport source (
		output valid, action, power_on, setpoint, adc_high_side, adc_low_side,
		input  ready
	);
	modport sink (
		input  valid, action, power_on, setpoint, adc_high_side, adc_low_side,
		output ready
	);
endinterface

// ----- rtl/core/ssm_result_if.sv -----
// ----------------------------------------------------------------------------
// ssm_result_if
// Result channel: drive state and measurement report per request.
// ----------------------------------------------------------------------------
interface ssm_result_if import ssm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              relay_on;
	logic [CMP_W-1:0]  voltage_compare;
	logic [CMP_W-1:0]  current_compare;
	logic              report_valid;
	logic [VOLT_W-1:0] measured_voltage;
	logic [CURR_W-1:0] measured_current;

	modport source (
		output valid, relay_on, voltage_compare, current_compare, report_valid,
			measured_voltage, measured_current,
		input  ready
	);
	modport sink (
		input  valid, relay_on, voltage_compare, current_compare, report_valid,
			measured_voltage, measured_current,
		output ready
	);
endinterface

// ----- rtl/core/ssm_div.sv -----
// ----------------------------------------------------------------------------
// ssm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssm_div import ssm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0]     work_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DEN_W:0]       shifted;
	logic [DEN_W:0]       trial;
	logic                 fits;

	assign shifted = {rem_q, work_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = !trial[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in behind the numerator
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DIV_W-2:0], fits};
			rem_q  <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

// ----- rtl/core/ssm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssm_ctrl
// Sequencer: decodes a request, runs the divisions, hands off the result.
// ----------------------------------------------------------------------------
module ssm_ctrl import ssm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ssm_status_t status,
	output ssm_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (status.action)
					ACT_RELAY: begin
						cmd.relay_set = 1'b1;
						state_d       = ST_DELIVER;
					end
					ACT_VSET: begin
						if (status.vsp_changed) begin
							cmd.store_vcmp = 1'b1;
						end
						state_d = ST_DELIVER;
					end
					ACT_CSET: begin
						if (status.csp_changed) begin
							cmd.store_ccmp = 1'b1;
							cmd.store_amps = 1'b1;
						end
						state_d = ST_DELIVER;
					end
					ACT_SAMPLE: begin
						cmd.accumulate = 1'b1;
						state_d        = ST_CHECK;
					end
				endcase
			end
			ST_CHECK: begin
				cmd.prep = 1'b1;
				if (status.window_full) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_VOLT;
					state_d       = ST_WAIT_VOLT;
				end else begin
					state_d = ST_DELIVER;
				end
			end
			ST_WAIT_VOLT: begin
				if (status.div_done) begin
					cmd.store_volt = 1'b1;
					if (status.plausible) begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DIV_CURR;
						state_d       = ST_WAIT_CURR;
					end else begin
						cmd.close_window = 1'b1;
						state_d          = ST_DELIVER;
					end
				end
			end
			ST_WAIT_CURR: begin
				if (status.div_done) begin
					cmd.store_curr   = 1'b1;
					cmd.close_window = 1'b1;
					state_d          = ST_DELIVER;
				end
			end
			ST_DELIVER: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/ssm_dp.sv -----
// ----------------------------------------------------------------------------
// ssm_dp
// Datapath: request latch, setpoint and window state, scaling products,
// shared divider and output register.
// ----------------------------------------------------------------------------
module ssm_dp import ssm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ssm_cmd_t          cmd,
	output ssm_status_t       status,
	input  logic [CNT_W-1:0]  sample_count,
	input  logic [ACT_W-1:0]  action,
	input  logic              power_on,
	input  logic [SP_W-1:0]   setpoint,
	input  logic [ADC_W-1:0]  adc_high_side,
	input  logic [ADC_W-1:0]  adc_low_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              relay_on,
	output logic [CMP_W-1:0]  voltage_compare,
	output logic [CMP_W-1:0]  current_compare,
	output logic              report_valid,
	output logic [VOLT_W-1:0] measured_voltage,
	output logic [CURR_W-1:0] measured_current
);

	// latched request
	logic [ACT_W-1:0]  action_q;
	logic              power_q;
	logic [SP_W-1:0]   sp_q;
	logic [ADC_W-1:0]  adc_a_q;
	logic [ADC_W-1:0]  adc_b_q;

	// block state
	logic              relay_q;
	logic [SP_W-1:0]   vsp_q;
	logic [SP_W-1:0]   csp_q;
	logic [CMP_W-1:0]  vcmp_q;
	logic [CMP_W-1:0]  ccmp_q;
	logic [AMPS_W-1:0] amps_q;
	logic [SUM_W-1:0]  sum_a_q;
	logic [SUM_W-1:0]  sum_b_q;
	logic [CNT_W-1:0]  pairs_q;
	logic [CURR_W-1:0] held_q;
	logic [VOLT_W-1:0] volt_q;
	logic              report_q;

	// report products
	logic              ge_q;
	logic [DIV_W-1:0]  cur_num_q;
	logic [LHS_W-1:0]  lhs_q;
	logic [LIM_W-1:0]  limit_q;

	// output register
	logic              out_valid_q;
	logic              o_relay_q;
	logic [CMP_W-1:0]  o_vcmp_q;
	logic [CMP_W-1:0]  o_ccmp_q;
	logic              o_report_q;
	logic [VOLT_W-1:0] o_volt_q;
	logic [CURR_W-1:0] o_curr_q;

	logic [CNT_W-1:0]       n;
	logic [SUM_W-1:0]       den;
	logic [SUM_W-1:0]       diff;
	logic [VNUM_W-1:0]      volt_num;
	logic [CMP_PROD_W-1:0]  cmp_prod;
	logic [AMPS_PROD_W-1:0] amps_prod;
	logic [DIV_W-1:0]       div_dvd;
	logic [DEN_W-1:0]       div_dvs;
	logic [DIV_W-1:0]       quot;
	logic                   div_done;

	// zero count behaves as one
	assign n        = (sample_count == '0) ? CNT_W'(1) : sample_count;
	assign den      = {n, 12'd0} - SUM_W'(n);               // n * 4095
	assign diff     = sum_a_q - sum_b_q;
	assign volt_num = VNUM_W'(sum_a_q) * VNUM_W'(CENTI_SCALE);
	// setpoint scaling: floor(sp*5/33) and floor(sp/1000)
	assign cmp_prod  = CMP_PROD_W'(sp_q) * CMP_PROD_W'(CMP_RECIP);
	assign amps_prod = AMPS_PROD_W'(sp_q) * AMPS_PROD_W'(AMPS_RECIP);

	assign div_dvs = DEN_W'(den);

	always_comb begin
		unique case (cmd.div_sel)
			DIV_VOLT: begin
				div_dvd = DIV_W'(volt_num);
			end
			DIV_CURR: begin
				div_dvd = cur_num_q;
			end
		endcase
	end

	ssm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			action_q <= action;
			power_q  <= power_on;
			sp_q     <= setpoint;
			adc_a_q  <= adc_high_side;
			adc_b_q  <= adc_low_side;
		end
		if (cmd.prep) begin
			ge_q      <= sum_a_q >= sum_b_q;
			cur_num_q <= DIV_W'(diff) * DIV_W'(CURRENT_SCALE);
			lhs_q     <= LHS_W'(diff) * LHS_W'(AMP_RATIO);
			limit_q   <= LIM_W'(amps_q) * LIM_W'(den);
		end
		if (cmd.store_volt) begin
			volt_q <= (quot > DIV_W'(4095)) ? '1 : quot[VOLT_W-1:0];
		end
		if (cmd.load_out) begin
			o_relay_q  <= relay_q;
			o_vcmp_q   <= vcmp_q;
			o_ccmp_q   <= ccmp_q;
			o_report_q <= report_q;
			o_volt_q   <= report_q ? volt_q : '0;
			o_curr_q   <= report_q ? held_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q     <= 1'b0;
			vsp_q       <= '0;
			csp_q       <= '0;
			vcmp_q      <= VCMP_RST;
			ccmp_q      <= '0;
			amps_q      <= '0;
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			pairs_q     <= '0;
			held_q      <= '0;
			report_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				report_q <= 1'b0;
			end
			if (cmd.relay_set) begin
				relay_q <= power_q;
			end
			if (cmd.store_vcmp) begin
				vsp_q  <= sp_q;
				vcmp_q <= cmp_prod[CMP_SHIFT +: CMP_W];
			end
			if (cmd.store_ccmp) begin
				csp_q  <= sp_q;
				ccmp_q <= cmp_prod[CMP_SHIFT +: CMP_W];
			end
			if (cmd.store_amps) begin
				amps_q <= amps_prod[AMPS_SHIFT +: AMPS_W];
			end
			if (cmd.store_curr) begin
				held_q <= (quot > DIV_W'(65535)) ? '1 : quot[CURR_W-1:0];
			end
			if (cmd.accumulate) begin
				sum_a_q <= sum_a_q + SUM_W'(adc_a_q);
				sum_b_q <= sum_b_q + SUM_W'(adc_b_q);
				pairs_q <= pairs_q + 1'b1;
			end else if (cmd.close_window) begin
				sum_a_q  <= '0;
				sum_b_q  <= '0;
				pairs_q  <= '0;
				report_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.action      = action_t'(action_q);
	assign status.vsp_changed = sp_q != vsp_q;
	assign status.csp_changed = sp_q != csp_q;
	assign status.window_full = pairs_q >= n;
	assign status.plausible   = ge_q && (lhs_q <= LHS_W'(limit_q));
	assign status.div_done    = div_done;
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_valid        = out_valid_q;
	assign relay_on         = o_relay_q;
	assign voltage_compare  = o_vcmp_q;
	assign current_compare  = o_ccmp_q;
	assign report_valid     = o_report_q;
	assign measured_voltage = o_volt_q;
	assign measured_current = o_curr_q;

endmodule

// ----- rtl/core/supply_setpoint_and_measurement.sv -----
// ----------------------------------------------------------------------------
// supply_setpoint_and_measurement
// Relay drive, setpoint-to-PWM conversion and averaged voltage / current
// measurement of a bench supply, with an APB register for the window length.
// ----------------------------------------------------------------------------
// Flow: a relay or setpoint request passes DECODE and DELIVER; a sample adds
//   CHECK, and a closing sample adds WAIT_VOLT and, if plausible, WAIT_CURR.
// Requests: one in flight, the next is taken after DELIVER, which waits while
//   the sink stalls; a closing sample runs the 41-step divider once or twice.
// Reset: arst_n clears sums, counts, setpoints and relay; the voltage compare
//   value comes up at 15, the window length at 7.
// ----------------------------------------------------------------------------
module supply_setpoint_and_measurement import ssm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	ssm_item_if.sink          item,
	ssm_result_if.source      result
);

	// window length register
	logic [CNT_W-1:0]     sample_count_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	ssm_cmd_t    cmd;
	ssm_status_t status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[REG_LSB +: REG_IDX_W];
	assign wr_en   = psel && penable && pwrite && pready;

	// writes past the register list are dropped, reads return zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RST;
		end else if (wr_en && reg_idx == REG_SAMPLE_COUNT) begin
			sample_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_SAMPLE_COUNT) begin
			prdata = APB_DW'(sample_count_q);
		end
	end

	// sequencer: owns the request handshake, one request in flight
	ssm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: the output register lets the next request in while a
	// result still waits on the sink
	ssm_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.sample_count     (sample_count_q),
		.action           (item.action),
		.power_on         (item.power_on),
		.setpoint         (item.setpoint),
		.adc_high_side    (item.adc_high_side),
		.adc_low_side     (item.adc_low_side),
		.out_valid        (result.valid),
		.out_ready        (result.ready),
		.relay_on         (result.relay_on),
		.voltage_compare  (result.voltage_compare),
		.current_compare  (result.current_compare),
		.report_valid     (result.report_valid),
		.measured_voltage (result.measured_voltage),
		.measured_current (result.measured_current)
	);

endmodule

// ----- rtl/core/ssm_checker.sv -----
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks of the supply setpoint and measurement block.
// ----------------------------------------------------------------------------
module ssm_checker import ssm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic              relay_on,
	input logic [CMP_W-1:0]  voltage_compare,
	input logic [CMP_W-1:0]  current_compare,
	input logic              report_valid,
	input logic [VOLT_W-1:0] measured_voltage,
	input logic [CURR_W-1:0] measured_current
);

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(relay_on) &&
		$stable(voltage_compare) && $stable(current_compare) &&
		$stable(report_valid) && $stable(measured_voltage) &&
		$stable(measured_current))
		else $error("result changed while stalled");

	// one request in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("request taken while another is in work");

	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !report_valid |->
		measured_voltage == '0 && measured_current == '0)
		else $error("measurement without a report");

	a_compare_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> voltage_compare <= CMP_W'(9929) &&
		current_compare <= CMP_W'(9929))
		else $error("compare value out of range");

endmodule

bind supply_setpoint_and_measurement ssm_checker u_ssm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item.valid),
	.item_ready       (item.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.relay_on         (result.relay_on),
	.voltage_compare  (result.voltage_compare),
	.current_compare  (result.current_compare),
	.report_valid     (result.report_valid),
	.measured_voltage (result.measured_voltage),
	.measured_current (result.measured_current)
);

// ----- tb/sv/tb_supply_setpoint_and_measurement.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_supply_setpoint_and_measurement
// Self-checking bench for the supply setpoint and measurement block. A
// clocked driver feeds requests from a queue, and a clocked monitor predicts
// one response per accepted request and compares it field by field with
// what the block returns. The window length register is written and read
// back over APB between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_supply_setpoint_and_measurement;
	import ssm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned TAIL_CYCLES = 120;  // > slowest divider pass
	localparam logic [APB_AW-1:0] WINDOW_ADDR = APB_AW'(REG_SAMPLE_COUNT) << REG_LSB;

	typedef struct packed {
		action_t           action;
		logic              power_on;
		logic [SP_W-1:0]   setpoint;
		logic [ADC_W-1:0]  high_side;
		logic [ADC_W-1:0]  low_side;
	} supply_req_t;

	typedef struct packed {
		logic              relay_on;
		logic [CMP_W-1:0]  vcmp;
		logic [CMP_W-1:0]  ccmp;
		logic              report_valid;
		logic [VOLT_W-1:0] volt;
		logic [CURR_W-1:0] curr;
	} supply_res_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	ssm_item_if   item_ch();
	ssm_result_if result_ch();

	supply_setpoint_and_measurement dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	initial forever #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow state of the block. Initial values match its reset values;
	// reset is applied exactly once, so no separate clear is needed.
	// ------------------------------------------------------------------
	logic [CNT_W-1:0]  window_cfg   = SAMPLE_COUNT_RST;
	logic [SUM_W-1:0]  hs_sum       = '0;
	logic [SUM_W-1:0]  ls_sum       = '0;
	logic [CNT_W-1:0]  pair_cnt     = '0;
	logic [CURR_W-1:0] held_amps    = '0;  // last plausible current, centiamps
	logic [SP_W-1:0]   csp_shadow   = '0;
	logic [SP_W-1:0]   vsp_shadow   = '0;
	logic [CMP_W-1:0]  vcmp_shadow  = VCMP_RST;
	logic [CMP_W-1:0]  ccmp_shadow  = '0;
	logic              relay_shadow = 1'b0;

	supply_req_t pending_requests[$];
	supply_res_t expected_responses[$];

	int unsigned issued_cnt   = 0;
	int unsigned accepted_cnt = 0;
	int unsigned checked_cnt  = 0;
	int unsigned report_cnt   = 0;
	int unsigned fresh_cnt    = 0;  // reports that took a new current
	int unsigned error_cnt    = 0;
	int unsigned cycle_cnt    = 0;

	// generator memory, used to repeat a setpoint now and then
	logic [SP_W-1:0] last_vsp = '0;
	logic [SP_W-1:0] last_csp = '0;

	// setpoint code -> PWM compare: floor(sp * 500 / 3300)
	function automatic logic [CMP_W-1:0] setpoint_to_compare(logic [SP_W-1:0] sp);
		longint unsigned q;
		q = (longint'(sp) * 500) / 3300;
		return q[CMP_W-1:0];
	endfunction

	// One request in, one response out; advances the shadow state.
	function automatic supply_res_t supply_response(supply_req_t r);
		supply_res_t     res;
		longint unsigned n, den, vq, diff, limit, cq;
		res = '0;
		case (r.action)
			ACT_RELAY: relay_shadow = r.power_on;
			ACT_VSET: begin
				// an unchanged setpoint leaves the compare value untouched
				if (r.setpoint != vsp_shadow) begin
					vsp_shadow  = r.setpoint;
					vcmp_shadow = setpoint_to_compare(r.setpoint);
				end
			end
			ACT_CSET: begin
				if (r.setpoint != csp_shadow) begin
					csp_shadow  = r.setpoint;
					ccmp_shadow = setpoint_to_compare(r.setpoint);
				end
			end
			default: begin
				n = (window_cfg == 0) ? 1 : window_cfg;  // zero length acts as one
				hs_sum   = hs_sum + SUM_W'(r.high_side);
				ls_sum   = ls_sum + SUM_W'(r.low_side);
				pair_cnt = pair_cnt + 1'b1;
				// >= rather than ==: the length may have been lowered mid-window
				if (pair_cnt >= n) begin
					den = n * 4095;
					vq  = (longint'(hs_sum) * 3300) / den;
					res.report_valid = 1'b1;
					res.volt = (vq > 4095) ? 12'd4095 : vq[VOLT_W-1:0];
					if (hs_sum >= ls_sum) begin
						diff  = hs_sum - ls_sum;
						limit = longint'(csp_shadow / 1000) * den;
						if (diff * 33000 <= limit) begin
							cq = (diff * 3300000) / den;
							held_amps = (cq > 65535) ? 16'hFFFF : cq[CURR_W-1:0];
							fresh_cnt++;
						end
					end
					// negative or over-limit current: keep the last good one
					res.curr = held_amps;
					report_cnt++;
					hs_sum   = '0;
					ls_sum   = '0;
					pair_cnt = '0;
				end
			end
		endcase
		res.relay_on = relay_shadow;
		res.vcmp     = vcmp_shadow;
		res.ccmp     = ccmp_shadow;
		return res;
	endfunction

	task automatic check_field(string what, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			error_cnt++;
		end
	endtask

	// ------------------------------------------------------------------
	// Request driver: bursts of random length, random gaps in between.
	// A request is held until the monitor saw it taken at the last edge.
	// ------------------------------------------------------------------
	logic        req_taken  = 1'b0;
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(negedge clk) begin
		supply_req_t nxt;
		if (arst_n && (!item_ch.valid || req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				item_ch.valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				nxt = pending_requests.pop_front();
				item_ch.valid         <= 1'b1;
				item_ch.action        <= nxt.action;
				item_ch.power_on      <= nxt.power_on;
				item_ch.setpoint      <= nxt.setpoint;
				item_ch.adc_high_side <= nxt.high_side;
				item_ch.adc_low_side  <= nxt.low_side;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					// mostly short gaps, some back-to-back, a few long enough
					// to let a divider pass finish with nothing queued
					if ($urandom_range(0, 3) == 0)
						gap_left = 0;
					else if ($urandom_range(0, 9) == 0)
						gap_left = $urandom_range(20, 100);
					else
						gap_left = $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Response ready: switches between runs of no stall, coin-flip stall,
	// one-in-five and light stall.
	// ------------------------------------------------------------------
	int unsigned stall_mode = 0;
	int unsigned stall_run  = 0;
	int unsigned stall_tick = 0;

	always @(negedge clk) begin
		logic rdy;
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run  = $urandom_range(20, 200);
		end
		stall_run--;
		stall_tick++;
		case (stall_mode)
			0:       rdy = 1'b1;
			1:       rdy = 1'($urandom_range(0, 1));
			2:       rdy = (stall_tick % 5 == 0);
			default: rdy = ($urandom_range(0, 7) != 0);
		endcase
		result_ch.ready <= rdy;
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each taken request, check each taken response.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		supply_req_t req;
		supply_res_t got, want;
		if (arst_n) begin
			req_taken <= item_ch.valid && item_ch.ready;
			if (item_ch.valid && item_ch.ready) begin
				req.action    = action_t'(item_ch.action);
				req.power_on  = item_ch.power_on;
				req.setpoint  = item_ch.setpoint;
				req.high_side = item_ch.adc_high_side;
				req.low_side  = item_ch.adc_low_side;
				expected_responses.push_back(supply_response(req));
				accepted_cnt++;
			end
			if (result_ch.valid && result_ch.ready) begin
				got.relay_on     = result_ch.relay_on;
				got.vcmp         = result_ch.voltage_compare;
				got.ccmp         = result_ch.current_compare;
				got.report_valid = result_ch.report_valid;
				got.volt         = result_ch.measured_voltage;
				got.curr         = result_ch.measured_current;
				if (expected_responses.size() == 0) begin
					$display("%0t: response with no request outstanding, got %p", $time, got);
					error_cnt++;
				end else begin
					want = expected_responses.pop_front();
					check_field("relay_on", want.relay_on, got.relay_on);
					check_field("voltage_compare", want.vcmp, got.vcmp);
					check_field("current_compare", want.ccmp, got.ccmp);
					check_field("report_valid", want.report_valid, got.report_valid);
					check_field("measured_voltage", want.volt, got.volt);
					check_field("measured_current", want.curr, got.curr);
					checked_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d responses still outstanding", $time,
				expected_responses.size());
			$display("** supply_setpoint_and_measurement: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// all fields random, so fields the action ignores still toggle
	function automatic supply_req_t random_req();
		supply_req_t r;
		r.action    = action_t'($urandom_range(0, 3));
		r.power_on  = 1'($urandom_range(0, 1));
		r.setpoint  = SP_W'($urandom_range(0, 65535));
		r.high_side = ADC_W'($urandom_range(0, 4095));
		r.low_side  = ADC_W'($urandom_range(0, 4095));
		return r;
	endfunction

	task automatic push_sample(int unsigned hi, int unsigned lo);
		supply_req_t r;
		r = random_req();
		r.action    = ACT_SAMPLE;
		r.high_side = ADC_W'(hi);
		r.low_side  = ADC_W'(lo);
		pending_requests.push_back(r);
		issued_cnt++;
	endtask

	task automatic push_cmd(action_t act, int unsigned val);
		supply_req_t r;
		r = random_req();
		r.action = act;
		if (act == ACT_RELAY) begin
			r.power_on = val[0];
		end else begin
			r.setpoint = SP_W'(val);
			if (act == ACT_VSET) last_vsp = SP_W'(val);
			else last_csp = SP_W'(val);
		end
		pending_requests.push_back(r);
		issued_cnt++;
	endtask

	task automatic wait_idle();
		while (accepted_cnt != issued_cnt || expected_responses.size() != 0)
			@(posedge clk);
	endtask

	// write the window length, then read it back; upper data bits are junk
	task automatic set_window(logic [CNT_W-1:0] len);
		logic [APB_DW-1:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= WINDOW_ADDR;
		pwdata  <= ($urandom() & ~APB_DW'(7'h7F)) | APB_DW'(len);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		window_cfg = len;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		check_field("window length readback", APB_DW'(len), rd);
	endtask

	// Random traffic: mostly ADC pairs, shaped one window at a time so that
	// windows with small positive differences (plausible current) dominate,
	// with negative, full-scale and unconstrained windows mixed in.
	task automatic gen_traffic(int unsigned n_items, int unsigned win);
		int unsigned made, in_win, n_eff, style, roll, hi, lo, d, sp;
		made   = 0;
		in_win = 0;
		n_eff  = (win == 0) ? 1 : win;
		style  = $urandom_range(0, 4);
		while (made < n_items) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				push_cmd(ACT_RELAY, $urandom_range(0, 1));
			end else if (roll < 14) begin
				sp = ($urandom_range(0, 5) == 0) ? 32'(last_vsp) : $urandom_range(0, 65535);
				push_cmd(ACT_VSET, sp);
			end else if (roll < 22) begin
				case ($urandom_range(0, 9))
					0, 1:    sp = 32'(last_csp);
					2, 3:    sp = $urandom_range(0, 999);  // zero amp limit
					4:       sp = $urandom_range(0, 65535);
					default: sp = $urandom_range(20000, 65535);
				endcase
				push_cmd(ACT_CSET, sp);
			end else begin
				case (style)
					0, 1: begin
						hi = $urandom_range(0, 4095);
						d  = $urandom_range(0, 6);
						lo = (hi >= d) ? hi - d : 0;
					end
					2: begin  // current into the supply
						hi = $urandom_range(0, 4000);
						lo = hi + $urandom_range(1, 95);
					end
					3: begin
						hi = $urandom_range(0, 4095);
						lo = $urandom_range(0, 4095);
					end
					default: begin
						hi = 4095;
						lo = 4095 - $urandom_range(0, 3);
					end
				endcase
				push_sample(hi, lo);
				in_win++;
				if (in_win >= n_eff) begin
					in_win = 0;
					style  = $urandom_range(0, 4);
				end
			end
			made++;
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	// phase plan: a long window ends each time with a partial window that
	// a shorter length then closes at the next pair
	int unsigned phase_len[10] = '{120, 400, 120, 100, 150, 120, 110, 110, 110, 110};
	logic [CNT_W-1:0] phase_win[10];

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		item_ch.valid   = 1'b0;
		item_ch.action  = ACT_RELAY;
		item_ch.power_on      = 1'b0;
		item_ch.setpoint      = '0;
		item_ch.adc_high_side = '0;
		item_ch.adc_low_side  = '0;
		result_ch.ready = 1'b0;

		phase_win = '{7'd1, 7'd127, 7'd3, 7'd0, 7'd127, 7'd2,
			7'($urandom_range(1, 20)), 7'($urandom_range(1, 127)),
			7'($urandom_range(1, 20)), 7'd7};

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed part at the reset window length of 7
		push_cmd(ACT_VSET, 0);      // equals the stored 0: compare stays 15
		push_cmd(ACT_CSET, 0);      // unchanged as well
		push_cmd(ACT_RELAY, 1);
		push_cmd(ACT_VSET, 65535);  // largest compare value
		push_cmd(ACT_VSET, 65535);  // repeat, no change
		push_cmd(ACT_CSET, 65535);  // 65 A limit
		push_cmd(ACT_RELAY, 0);
		// small positive difference: plausible, fresh current
		push_sample(4095, 4090);
		push_sample(4095, 4095);
		push_sample(0, 0);
		push_sample(4095, 4088);
		push_sample(2048, 2047);
		push_sample(4095, 4094);
		push_sample(1, 0);
		// low side above high side: current held from the last window
		push_sample(0, 4095);
		push_sample(4095, 0);
		push_sample(0, 4095);
		push_sample(0, 4095);
		push_sample(4095, 4095);
		push_sample(0, 0);
		push_sample(100, 4095);
		wait_idle();

		for (int p = 0; p < 10; p++) begin
			set_window(phase_win[p]);
			gen_traffic(phase_len[p], phase_win[p]);
			wait_idle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d requests over window lengths 0 to 127; %0d responses checked.",
			issued_cnt, checked_cnt);
		$display("%0d measurement reports, %0d with a fresh current, %0d mismatches.",
			report_cnt, fresh_cnt, error_cnt);
		if (error_cnt == 0 && expected_responses.size() == 0) begin
			$display("** supply_setpoint_and_measurement: PASSED **");
		end else begin
			$display("** supply_setpoint_and_measurement: FAILED **");
		end
		$finish;
	end

endmodule
